### hdl/tlr_pkg.sv
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared types and codes of the timed linear ramp: register indexes,
// controller states and the command and status groups between controller
// and datapath.
// ----------------------------------------------------------------------------
package tlr_pkg;

  localparam int CFG_INDEX_W = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_VALUE     = 8'd0,
    REG_TARGET_VALUE    = 8'd1,
    REG_RAMP_START_TIME = 8'd2,
    REG_RAMP_DURATION   = 8'd3
  } tlr_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_PUT
  } tlr_state_t;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_step;
    logic out_load;
  } tlr_cmd_t;

  typedef struct packed {
    logic go;
    logic out_free;
  } tlr_status_t;

endpackage

### hdl/tlr_ctrl.sv
// ----------------------------------------------------------------------------
// tlr_ctrl
// Sequencer of the ramp: accepts a sample, steps the multiplier and divider
// one bit a cycle if the ramp is running, then loads the output register.
// ----------------------------------------------------------------------------
module tlr_ctrl import tlr_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int TIME_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  tlr_status_t status,
  output tlr_cmd_t    cmd
);

  localparam int MAX_STEPS = (VALUE_WIDTH > TIME_WIDTH) ? VALUE_WIDTH : TIME_WIDTH;
  localparam int CNT_W     = $clog2(MAX_STEPS);

  tlr_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.go) begin
            state_next = ST_MUL;
            cnt_next   = CNT_W'(TIME_WIDTH - 1);
          end else begin
            state_next = ST_PUT;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_DIV;
          cnt_next   = CNT_W'(VALUE_WIDTH - 1);
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_PUT;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_PUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_load_needs_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded while output register busy");

  a_skip_to_put: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && !status.go) |=> (state == ST_PUT))
    else $error("target-only sample did not go straight to output");

  a_mul_to_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL && cnt == '0) |=> (state == ST_DIV && cnt == CNT_W'(VALUE_WIDTH - 1)))
    else $error("divider not started after last multiply step");

endmodule

### hdl/tlr_datapath.sv
// ----------------------------------------------------------------------------
// tlr_datapath
// Configuration registers, expired flag, shift-add multiplier and restoring
// divider sharing one product register, and the output register.
// ----------------------------------------------------------------------------
module tlr_datapath import tlr_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [(VALUE_WIDTH > TIME_WIDTH ? VALUE_WIDTH : TIME_WIDTH)-1:0] cfg_data,
  input  logic [TIME_WIDTH-1:0]         current_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] setpoint,
  output logic                          ramping,
  input  tlr_cmd_t                      cmd,
  output tlr_status_t                   status
);

  localparam int VW = VALUE_WIDTH;
  localparam int TW = TIME_WIDTH;
  localparam int PW = VW + TW;

  logic signed [VW-1:0] start_value;
  logic signed [VW-1:0] target_value;
  logic [TW-1:0]        ramp_start_time;
  logic [TW-1:0]        ramp_duration;
  logic                 ramp_expired;
  logic                 ramp_on;
  logic [PW-1:0]        prod;

  logic [TW:0]    elapsed;
  logic [VW:0]    delta;
  logic [VW:0]    mag_full;
  logic [VW-1:0]  mag;
  logic           neg;
  logic [VW:0]    mul_sum;
  logic [TW-1:0]  rem;
  logic [VW-1:0]  quo;
  logic [TW:0]    trial;
  logic [TW:0]    trial_diff;
  logic           qbit;
  logic [TW-1:0]  rem_next;
  logic [VW-1:0]  ramp_value;

  assign elapsed  = {1'b0, current_time} - {1'b0, ramp_start_time};
  assign delta    = {target_value[VW-1], target_value} - {start_value[VW-1], start_value};
  assign neg      = delta[VW];
  assign mag_full = neg ? (~delta + 1'b1) : delta;
  assign mag      = mag_full[VW-1:0];

  assign status.go = !ramp_expired && (ramp_duration != '0) && !elapsed[TW]
                     && (elapsed[TW-1:0] != '0) && (elapsed[TW-1:0] < ramp_duration);
  assign status.out_free = !out_valid || !out_stall;

  assign mul_sum = {1'b0, prod[PW-1:TW]} + (prod[0] ? {1'b0, mag} : '0);

  assign rem        = prod[PW-1:VW];
  assign quo        = prod[VW-1:0];
  assign trial      = {rem, quo[VW-1]};
  assign trial_diff = trial - {1'b0, ramp_duration};
  assign qbit       = !trial_diff[TW];
  assign rem_next   = qbit ? trial_diff[TW-1:0] : trial[TW-1:0];

  assign ramp_value = neg ? (start_value - quo) : (start_value + quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_value     <= '0;
      target_value    <= '0;
      ramp_start_time <= '0;
      ramp_duration   <= '0;
      ramp_expired    <= 1'b0;
    end else begin
      if (cmd.load && !status.go) begin
        ramp_expired <= 1'b1;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_START_VALUE: begin
            start_value  <= cfg_data[VW-1:0];
            ramp_expired <= 1'b0;
          end
          REG_TARGET_VALUE: begin
            target_value <= cfg_data[VW-1:0];
            ramp_expired <= 1'b0;
          end
          REG_RAMP_START_TIME: begin
            ramp_start_time <= cfg_data[TW-1:0];
            ramp_expired    <= 1'b0;
          end
          REG_RAMP_DURATION: begin
            ramp_duration <= cfg_data[TW-1:0];
            ramp_expired  <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod    <= {{VW{1'b0}}, elapsed[TW-1:0]};
      ramp_on <= status.go;
    end else if (cmd.mul_step) begin
      prod <= {mul_sum, prod[TW-1:1]};
    end else if (cmd.div_step) begin
      prod <= {rem_next, quo[VW-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      setpoint <= ramp_on ? ramp_value : target_value;
      ramping  <= ramp_on;
    end
  end

endmodule

### hdl/timed_linear_ramp.sv
// ----------------------------------------------------------------------------
// timed_linear_ramp
// Setpoint that moves in a straight line from a start value to a target
// value over a programmed time window.
// ----------------------------------------------------------------------------
// Each time sample gives one setpoint. A sample inside the ramp window goes
// one bit per cycle through a shift-add multiplier, then one quotient bit per
// cycle through a restoring divider that reuses the same product register.
// A sample outside the window, or after expiry, skips both and goes straight
// to the output register. One sample is in work at a time; a new sample is
// taken while the previous result still waits in the output register.
// Configuration writes are always ready, and a write to one of the four
// registers clears the expired flag.
module timed_linear_ramp import tlr_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [(VALUE_WIDTH > TIME_WIDTH ? VALUE_WIDTH : TIME_WIDTH)-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [TIME_WIDTH-1:0]         current_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] setpoint,
  output logic                          ramping
);

  tlr_cmd_t    cmd;
  tlr_status_t status;

  assign cfg_ready = 1'b1;

  tlr_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tlr_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .current_time (current_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .setpoint     (setpoint),
    .ramping      (ramping),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
